@@ src/assert_macros.svh @@
// assertion macros shared by the ordered set table rtl
// expects clk and rst in the scope of each use; define NO_ASSERTIONS to drop them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// ante implies cons in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
// ante implies cons in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/ost_pkg.sv @@
// shared constants, codes and controller/datapath structs of the ordered set table
// no dependencies
`default_nettype none
package ost_pkg;

  localparam int CAPACITY = 16;
  localparam int ELEM_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // port widths fixed by the request and result formats
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 3;
  localparam int ELEM_OUT_W = 32;
  localparam int COUNT_OUT_W = 5;

  // request codes
  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_DEL   = 3'd1;
  localparam logic [2:0] CMD_LOC   = 3'd2;
  localparam logic [2:0] CMD_UNION = 3'd3;
  localparam logic [2:0] CMD_INTER = 3'd4;
  localparam logic [2:0] CMD_DIFF  = 3'd5;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_DUP     = 2'd1;
  localparam logic [1:0] STAT_MISSING = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  // source of the result element
  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_KEY  = 2'd1;
  localparam logic [1:0] SRC_PEND = 2'd2;

  typedef struct packed {
    logic             scanning;
    logic             sel;
    logic             phase;
    logic [CNT_W-1:0] ix;
    logic             do_add;
    logic             do_del;
    logic             load_pend;
    logic             load_out;
    logic             out_has;
    logic [1:0]       out_status;
    logic [1:0]       out_src;
    logic             out_last;
  } ost_cmd_t;

  typedef struct packed {
    logic hit;
    logic full;
    logic cand_live;
    logic other_hit;
    logic out_free;
  } ost_stat_t;

endpackage
`default_nettype wire

@@ src/ost_dp.sv @@
// datapath of the ordered set table: both sets, parallel compare rows, pending and output registers
// depends on ost_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module ost_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ost_pkg::ost_cmd_t            cmd,
  input  wire logic [ost_pkg::S_TDATA_W-1:0] s_tdata,
  input  wire logic                         m_tready,
  output ost_pkg::ost_stat_t                stat,
  output logic                              m_tvalid,
  output logic [ost_pkg::M_TDATA_W-1:0]     m_tdata,
  output logic [ost_pkg::M_TUSER_W-1:0]     m_tuser,
  output logic                              m_tlast
);
  import ost_pkg::*;

  logic [ELEM_W-1:0] cells [2][CAPACITY];
  logic [CNT_W-1:0]  cnt [2];
  logic [ELEM_W-1:0] pend;

  logic [ELEM_OUT_W-1:0]  out_elem;
  logic                   out_has;
  logic [1:0]             out_status;
  logic [COUNT_OUT_W-1:0] out_count;
  logic                   out_last;

  logic              rd_b;
  logic [IDX_W-1:0]  ixs;
  logic [ELEM_W-1:0] cand;
  logic [ELEM_W-1:0] key;
  logic [CAPACITY-1:0] match [2];
  logic [CAPACITY-1:0] ge [2];
  logic [CNT_W-1:0]  tcnt;
  logic [CNT_W-1:0]  cnt_after;
  logic [ELEM_OUT_W-1:0] elem_sel;

  assign rd_b = cmd.sel ^ cmd.phase;
  assign ixs  = cmd.ix[IDX_W-1:0];
  assign cand = cells[rd_b][ixs];
  assign key  = cmd.scanning ? cand : ELEM_W'(s_tdata);
  assign tcnt = cnt[cmd.sel];

  // compare row per set, masked to live slots; gap-closing mask from first hit upward
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        match[s][i] = (cells[s][i] == key) && (CNT_W'(i) < cnt[s]);
      end
      ge[s][0] = match[s][0];
      for (int i = 1; i < CAPACITY; i++) begin
        ge[s][i] = ge[s][i-1] | match[s][i];
      end
    end
  end

  always_comb begin
    stat.hit       = |match[cmd.sel];
    stat.full      = (tcnt == CNT_W'(CAPACITY));
    stat.cand_live = cmd.ix < cnt[rd_b];
    stat.other_hit = |match[~rd_b];
    stat.out_free  = !m_tvalid || m_tready;
  end

  always_comb begin
    if (cmd.do_add) begin
      cnt_after = tcnt + CNT_W'(1);
    end else if (cmd.do_del) begin
      cnt_after = tcnt - CNT_W'(1);
    end else begin
      cnt_after = tcnt;
    end
    case (cmd.out_src)
      SRC_KEY:  elem_sel = ELEM_OUT_W'(key);
      SRC_PEND: elem_sel = ELEM_OUT_W'(pend);
      default:  elem_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt[0] <= '0;
      cnt[1] <= '0;
    end else begin
      if (cmd.do_add) begin
        cnt[cmd.sel] <= tcnt + CNT_W'(1);
      end else if (cmd.do_del) begin
        cnt[cmd.sel] <= tcnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_add) begin
      cells[cmd.sel][tcnt[IDX_W-1:0]] <= key;
    end
    if (cmd.do_del) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (ge[cmd.sel][i]) begin
          cells[cmd.sel][i] <= cells[cmd.sel][i+1];
        end
      end
    end
    if (cmd.load_pend) begin
      pend <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_elem   <= elem_sel;
      out_has    <= cmd.out_has;
      out_status <= cmd.out_status;
      out_count  <= COUNT_OUT_W'(cnt_after);
      out_last   <= cmd.out_last;
    end
  end

  assign m_tdata = {{(M_TDATA_W - ELEM_OUT_W - COUNT_OUT_W){1'b0}}, out_count, out_elem};
  assign m_tuser = {out_status, out_has};
  assign m_tlast = out_last;

  `ASSERT_IMPL(a_cnt_a_bound, 1'b1, cnt[0] <= CNT_W'(CAPACITY))
  `ASSERT_IMPL(a_cnt_b_bound, 1'b1, cnt[1] <= CNT_W'(CAPACITY))
  `ASSERT_NEXT(a_add_grows, cmd.do_add, cnt[$past(cmd.sel)] == $past(tcnt) + CNT_W'(1))

endmodule
`default_nettype wire

@@ src/ost_ctrl.sv @@
// controller of the ordered set table: request decode, scan sequencing and output pacing
// depends on ost_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module ost_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  input  wire logic [ost_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                               s_tready,
  input  wire ost_pkg::ost_stat_t            stat,
  output ost_pkg::ost_cmd_t                  cmd
);
  import ost_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic             state, state_next;
  logic [2:0]       op_cmd, op_cmd_next;
  logic             op_sel, op_sel_next;
  logic             phase, phase_next;
  logic [CNT_W-1:0] ix, ix_next;
  logic             pend_valid, pend_valid_next;
  logic             qual;
  logic [2:0]       in_cmd;

  assign in_cmd = s_tuser[2:0];

  always_comb begin
    state_next      = state;
    op_cmd_next     = op_cmd;
    op_sel_next     = op_sel;
    phase_next      = phase;
    ix_next         = ix;
    pend_valid_next = pend_valid;
    qual            = 1'b0;
    s_tready        = 1'b0;

    cmd            = '0;
    cmd.out_src    = SRC_ZERO;
    cmd.out_status = STAT_OK;
    cmd.out_last   = 1'b1;

    case (state)
      S_IDLE: begin
        cmd.sel  = s_tuser[3];
        s_tready = stat.out_free;
        if (s_tvalid && stat.out_free) begin
          case (in_cmd)
            CMD_ADD: begin
              cmd.load_out = 1'b1;
              if (stat.hit) begin
                cmd.out_status = STAT_DUP;
              end else if (stat.full) begin
                cmd.out_status = STAT_FULL;
              end else begin
                cmd.do_add = 1'b1;
              end
            end
            CMD_DEL: begin
              cmd.load_out = 1'b1;
              if (stat.hit) begin
                cmd.do_del = 1'b1;
              end else begin
                cmd.out_status = STAT_MISSING;
              end
            end
            CMD_LOC: begin
              cmd.load_out = 1'b1;
              if (stat.hit) begin
                cmd.out_has = 1'b1;
                cmd.out_src = SRC_KEY;
              end else begin
                cmd.out_status = STAT_MISSING;
              end
            end
            CMD_UNION, CMD_INTER, CMD_DIFF: begin
              op_cmd_next     = in_cmd;
              op_sel_next     = s_tuser[3];
              phase_next      = 1'b0;
              ix_next         = '0;
              pend_valid_next = 1'b0;
              state_next      = S_SCAN;
            end
            default: begin
              cmd.load_out = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scanning = 1'b1;
        cmd.sel      = op_sel;
        cmd.phase    = phase;
        cmd.ix       = ix;
        if (phase) begin
          qual = !stat.other_hit;
        end else begin
          case (op_cmd)
            CMD_UNION: qual = 1'b1;
            CMD_INTER: qual = stat.other_hit;
            default:   qual = !stat.other_hit;
          endcase
        end
        if (stat.cand_live) begin
          // one element a step unless output stalls; held one leaves once next is known
          if (!(qual && pend_valid && !stat.out_free)) begin
            ix_next = ix + CNT_W'(1);
            if (qual) begin
              cmd.load_pend   = 1'b1;
              pend_valid_next = 1'b1;
              if (pend_valid) begin
                cmd.load_out = 1'b1;
                cmd.out_has  = 1'b1;
                cmd.out_src  = SRC_PEND;
                cmd.out_last = 1'b0;
              end
            end
          end
        end else if (!phase && (op_cmd == CMD_UNION)) begin
          phase_next = 1'b1;
          ix_next    = '0;
        end else if (stat.out_free) begin
          // closing item: held element, or the empty marker
          cmd.load_out    = 1'b1;
          cmd.out_has     = pend_valid;
          cmd.out_src     = pend_valid ? SRC_PEND : SRC_ZERO;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      phase      <= 1'b0;
      ix         <= '0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      phase      <= phase_next;
      ix         <= ix_next;
    end
  end

  always_ff @(posedge clk) begin
    op_cmd <= op_cmd_next;
    op_sel <= op_sel_next;
  end

  `ASSERT_IMPL(a_load_when_free, cmd.load_out, stat.out_free)
  `ASSERT_IMPL(a_pend_only_scan, pend_valid, state == S_SCAN)
  `ASSERT_IMPL(a_one_update, cmd.do_add || cmd.do_del, !(cmd.do_add && cmd.do_del) && (state == S_IDLE))

endmodule
`default_nettype wire

@@ src/ordered_set_table_core.sv @@
// top level of the ordered set table: two bounded insertion-ordered sets with set operations
// depends on ost_pkg, ost_ctrl and ost_dp
`default_nettype none
// Keeps two sets, A and B, of up to 16 distinct 32-bit elements each, in insertion order.
// A request carries a command and a set select in s_tuser and the element in s_tdata.
// Add, delete and locate compare the element against every slot of the target set at once
// and finish in the cycle they are accepted: one result per cycle while m_tready stays high.
// Union, intersection and difference scan the first set one slot per cycle while the output
// is not stalled (and, for union, the second set after it), testing each element against the
// whole other set in parallel; each qualifying element is held back so that the final one can
// carry m_tlast. No new request is taken until the last result of such a request is in the
// output register. An empty result gives a single item with no element and m_tlast set. A
// result register sits in front of the master port; a new request is taken in the cycle the
// held result is accepted, and a stalled result holds s_tready low. Slots that were never
// written are never read; no clearing pass runs after reset.
module ordered_set_table_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request side
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [ost_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] elem_value
  input  wire logic [ost_pkg::S_TUSER_W-1:0] s_tuser,  // [2:0] cmd, [3] which_set
  // result side
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [ost_pkg::M_TDATA_W-1:0]      m_tdata,  // [31:0] elem_out, [36:32] set_count
  output logic [ost_pkg::M_TUSER_W-1:0]      m_tuser,  // [0] has_element, [2:1] status
  output logic                               m_tlast   // last item of the request
);
  import ost_pkg::*;

  // command and status bundles between sequencer and datapath
  ost_cmd_t  cmd;
  ost_stat_t stat;

  // decode, scan sequencing, output pacing
  ost_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // set storage, compare rows, held element, result register
  ost_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
